// ===== rtl/core/vfs_pkg.sv =====
// ----------------------------------------------------------------------------
// vfs_pkg
// Shared types and constants for the velocity fluctuation statistics block:
// accumulator growth, item codes, queue depth and the back-end sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package vfs_pkg;

  // configuration register width and indexes
  localparam int CFG_W = 11;
  localparam logic REG_PPF = 1'b0;
  localparam logic REG_FC  = 1'b1;

  // accumulator growth over the velocity width
  localparam int FRAME_GROW = 10;  // frame and time sums of x and y
  localparam int SQ_GROW    = 10;  // frame squared norm sums
  localparam int RUN_GROW   = 20;  // run sums of x and y
  localparam int RSQ_GROW   = 16;  // run squared norm sums

  // input item codes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // queue entry kinds
  localparam logic ENT_FRAME  = 1'b0;
  localparam logic ENT_FINISH = 1'b1;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic            empty;
    logic [Q_CW-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // back-end sequencer
  localparam int STEP_W = 3;

  // divide steps of a frame close
  localparam logic [STEP_W-1:0] ST_X   = 3'd0;
  localparam logic [STEP_W-1:0] ST_Y   = 3'd1;
  localparam logic [STEP_W-1:0] ST_SQ  = 3'd2;
  // divide steps of a finish (x and y as above)
  localparam logic [STEP_W-1:0] ST_TX  = 3'd2;
  localparam logic [STEP_W-1:0] ST_TY  = 3'd3;
  localparam logic [STEP_W-1:0] ST_SV  = 3'd4;
  localparam logic [STEP_W-1:0] ST_TSQ = 3'd5;
  localparam logic [STEP_W-1:0] ST_RSQ = 3'd6;

  localparam logic [STEP_W-1:0] FR_LAST_DIV  = 3'd2;
  localparam logic [STEP_W-1:0] FIN_LAST_DIV = 3'd6;
  localparam logic [STEP_W-1:0] FR_LAST_MUL  = 3'd1;
  localparam logic [STEP_W-1:0] FIN_LAST_MUL = 3'd3;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_SQRT,
    BK_UPDATE,
    BK_EMIT
  } bk_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/vfs_queue.sv =====
// ----------------------------------------------------------------------------
// vfs_queue
// Short in-order queue carrying frame-close and finish entries from the
// front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vfs_queue #(
  parameter int W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [W-1:0]     push_data,
  input  wire logic             pop,
  output vfs_pkg::q_stat_t      q_stat,
  output logic      [W-1:0]     head
);

  localparam int PW = (vfs_pkg::Q_DEPTH > 1) ? $clog2(vfs_pkg::Q_DEPTH) : 1;
  localparam logic [PW-1:0] LAST = PW'(vfs_pkg::Q_DEPTH - 1);

  logic [W-1:0]              mem [vfs_pkg::Q_DEPTH];
  logic [PW-1:0]             wr_ptr;
  logic [PW-1:0]             rd_ptr;
  logic [vfs_pkg::Q_CW-1:0]  count;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign head         = mem[rd_ptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.count = count;

  // no write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (32'(count) < vfs_pkg::Q_DEPTH))
    else $error("queue written while full");

  // no read from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue popped while empty");

  // a lone write raises the fill level by one
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue fill level out of step");

endmodule

`default_nettype wire

// ===== rtl/core/vfs_front.sv =====
// ----------------------------------------------------------------------------
// vfs_front
// Front end: accepts sample and finish transactions, squares the velocities,
// accumulates the frame sums and hands closed frames and finish marks to
// the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vfs_front #(
  parameter int V  = 24,
  parameter int PW = 11,
  parameter int FW = 11,
  parameter int EW = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                mode,
  input  wire logic signed [V-1:0] adv_vx,
  input  wire logic signed [V-1:0] adv_vy,
  input  wire logic signed [V-1:0] com_vx,
  input  wire logic signed [V-1:0] com_vy,
  input  wire logic [PW-1:0]       p_eff,
  input  wire logic [FW-1:0]       f_eff,
  input  vfs_pkg::q_stat_t         q_stat,
  output logic                     push,
  output logic [EW-1:0]            push_data
);

  localparam int FXY = V + vfs_pkg::FRAME_GROW;
  localparam int FSQ = 2 * V + vfs_pkg::SQ_GROW;
  localparam int NSQ = 2 * V + 1;

  logic                 accept;
  logic [PW-1:0]        pcnt;
  logic [PW:0]          pcnt_inc;
  logic                 close_now;
  logic                 room;

  // stage a: registered velocities and squared norms
  logic                 a_valid;
  logic                 a_fin;
  logic                 a_close;
  logic signed [V-1:0]  a_v   [4];
  logic [NSQ-1:0]       a_nsq [2];
  logic [PW-1:0]        a_p;
  logic [FW-1:0]        a_f;

  logic signed [V-1:0]   in_v  [4];
  logic signed [2*V-1:0] in_sq [4];

  // frame accumulators
  logic signed [FXY-1:0] fsum     [4];
  logic [FSQ-1:0]        fsq      [2];
  logic signed [FXY-1:0] fsum_new [4];
  logic [FSQ-1:0]        fsq_new  [2];

  assign in_v[0] = adv_vx;
  assign in_v[1] = adv_vy;
  assign in_v[2] = com_vx;
  assign in_v[3] = com_vy;

  // frame close test and queue room
  assign pcnt_inc  = {1'b0, pcnt} + 1'b1;
  assign close_now = (pcnt_inc >= {1'b0, p_eff});
  assign push      = a_valid && (a_fin || a_close);
  assign room      = (32'(q_stat.count) + 32'(push)) < vfs_pkg::Q_DEPTH;
  assign in_ready  = room || ((mode == vfs_pkg::MODE_SAMPLE) && !close_now);
  assign accept    = in_valid && in_ready;

  // point counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pcnt    <= '0;
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      if (accept) begin
        if ((mode == vfs_pkg::MODE_FINISH) || close_now) begin
          pcnt <= '0;
        end else begin
          pcnt <= pcnt_inc[PW-1:0];
        end
      end
    end
  end

  // squares of the incoming components
  for (genvar i = 0; i < 4; i++) begin : g_sq
    assign in_sq[i] = in_v[i] * in_v[i];
  end

  // stage a payload
  always_ff @(posedge clk) begin
    if (accept) begin
      a_fin   <= (mode == vfs_pkg::MODE_FINISH);
      a_close <= (mode == vfs_pkg::MODE_SAMPLE) && close_now;
      a_p     <= p_eff;
      a_f     <= f_eff;
      for (int i = 0; i < 4; i++) begin
        a_v[i] <= in_v[i];
      end
      for (int k = 0; k < 2; k++) begin
        a_nsq[k] <= {1'b0, in_sq[2*k]} + {1'b0, in_sq[2*k+1]};
      end
    end
  end

  // saturating frame sums
  for (genvar i = 0; i < 4; i++) begin : g_fsum
    logic signed [FXY:0] s;
    assign s = {fsum[i][FXY-1], fsum[i]} + (FXY+1)'(a_v[i]);
    always_comb begin
      if (s[FXY] != s[FXY-1]) begin
        fsum_new[i] = s[FXY] ? {1'b1, {(FXY-1){1'b0}}} : {1'b0, {(FXY-1){1'b1}}};
      end else begin
        fsum_new[i] = s[FXY-1:0];
      end
    end
  end

  for (genvar k = 0; k < 2; k++) begin : g_fsq
    logic [FSQ:0] s;
    assign s = {1'b0, fsq[k]} + (FSQ+1)'(a_nsq[k]);
    assign fsq_new[k] = s[FSQ] ? {FSQ{1'b1}} : s[FSQ-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        fsum[i] <= '0;
      end
      for (int k = 0; k < 2; k++) begin
        fsq[k] <= '0;
      end
    end else if (a_valid) begin
      for (int i = 0; i < 4; i++) begin
        fsum[i] <= (a_fin || a_close) ? '0 : fsum_new[i];
      end
      for (int k = 0; k < 2; k++) begin
        fsq[k] <= (a_fin || a_close) ? '0 : fsq_new[k];
      end
    end
  end

  // queue entry
  assign push_data = {(a_fin ? vfs_pkg::ENT_FINISH : vfs_pkg::ENT_FRAME), a_p, a_f,
                      fsq_new[1], fsq_new[0],
                      fsum_new[3], fsum_new[2], fsum_new[1], fsum_new[0]};

endmodule

`default_nettype wire

// ===== rtl/core/vfs_div.sv =====
// ----------------------------------------------------------------------------
// vfs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vfs_div #(
  parameter int DW  = 64,
  parameter int NDW = 22
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DW-1:0]    dividend,
  input  wire logic [NDW-1:0]   divisor,
  output vfs_pkg::div_stat_t    div_stat,
  output logic [DW-1:0]         quotient
);

  localparam int CW = $clog2(DW + 1);

  logic            busy;
  logic            done;
  logic [CW-1:0]   cnt;
  logic [NDW-1:0]  rem;
  logic [NDW-1:0]  dvs;
  logic [DW-1:0]   quo;
  logic [NDW:0]    sh;
  logic [NDW:0]    diff;

  // shift in the next dividend bit and trial subtract
  assign sh   = {rem, quo[DW-1]};
  assign diff = sh - {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(DW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (sh >= {1'b0, dvs}) begin
        rem <= diff[NDW-1:0];
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= sh[NDW-1:0];
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

  assign div_stat.busy = busy;
  assign div_stat.done = done;
  assign quotient      = quo;

endmodule

`default_nettype wire

// ===== rtl/core/vfs_back.sv =====
// ----------------------------------------------------------------------------
// vfs_back
// Back end: sequences the shared divider, a squaring multiplier and a
// square root over queue entries, keeps the run totals and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module vfs_back #(
  parameter int V  = 24,
  parameter int PW = 11,
  parameter int FW = 11,
  parameter int EW = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [EW-1:0]        head,
  input  vfs_pkg::q_stat_t          q_stat,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      velocity_kind,
  output logic signed [V-1:0]       mean_x,
  output logic signed [V-1:0]       mean_y,
  output logic [V-1:0]              mean_speed,
  output logic [2*V-1:0]            space_var,
  output logic [2*V-1:0]            time_var,
  output logic [2*V-1:0]            ensemble_var,
  output logic                      last_result
);

  localparam int FXY  = V + vfs_pkg::FRAME_GROW;
  localparam int FSQ  = 2 * V + vfs_pkg::SQ_GROW;
  localparam int RXY  = V + vfs_pkg::RUN_GROW;
  localparam int RSQ  = 2 * V + vfs_pkg::RSQ_GROW;
  localparam int DW   = RSQ;
  localparam int NW   = RSQ;
  localparam int NDW  = PW + FW;
  localparam int VARW = 2 * V;
  localparam int MW   = FXY;
  localparam int SCW  = $clog2(V + 1);
  localparam logic [DW-1:0] POS_LIM = {{(DW-V+1){1'b0}}, {(V-1){1'b1}}};
  localparam logic [DW-1:0] NEG_LIM = POS_LIM + 1'b1;

  typedef logic [vfs_pkg::STEP_W-1:0] step_t;

  // queue entry fields
  logic signed [FXY-1:0] e_fx  [4];
  logic [FSQ-1:0]        e_fsq [2];
  logic [FW-1:0]         e_f;
  logic [PW-1:0]         e_p;
  logic                  e_kind;

  for (genvar i = 0; i < 4; i++) begin : g_efx
    assign e_fx[i] = head[i*FXY +: FXY];
  end
  for (genvar k = 0; k < 2; k++) begin : g_efsq
    assign e_fsq[k] = head[4*FXY + k*FSQ +: FSQ];
  end
  assign e_f    = head[4*FXY + 2*FSQ +: FW];
  assign e_p    = head[4*FXY + 2*FSQ + FW +: PW];
  assign e_kind = head[EW-1];

  // sequencer state
  vfs_pkg::bk_state_t state, state_next;
  step_t              step, step_next;
  logic               kind, kind_next;
  logic [NDW-1:0]     nreg;

  // run totals
  logic signed [RXY-1:0] rxy [4];
  logic [RSQ-1:0]        rsq [2];
  logic signed [FXY-1:0] txy [4];
  logic [FSQ-1:0]        tsq [2];
  logic [FSQ-1:0]        svs [2];

  // intermediate results
  logic [DW-1:0]         q   [7];
  logic [NW-1:0]         sq  [4];
  logic [2*V-1:0]        sr_rad;
  logic [V+1:0]          sr_rem;
  logic [V-1:0]          sr_root;
  logic [SCW-1:0]        sr_cnt;

  // control strobes
  logic                  div_start;
  logic                  q_we;
  logic                  mul_we;
  logic                  sqrt_init;
  logic                  sqrt_run;
  logic                  upd_we;
  logic                  out_load;
  logic                  clr_run;
  logic                  n_load;

  vfs_pkg::div_stat_t    div_stat;
  logic [DW-1:0]         div_a;
  logic [NDW-1:0]        div_b;
  logic [DW-1:0]         div_q;

  logic [1:0]            ix;
  logic [1:0]            iy;
  step_t                 last_div;
  step_t                 last_mul;

  assign ix       = {kind, 1'b0};
  assign iy       = {kind, 1'b1};
  assign last_div = (e_kind == vfs_pkg::ENT_FRAME) ? vfs_pkg::FR_LAST_DIV
                                                   : vfs_pkg::FIN_LAST_DIV;
  assign last_mul = (e_kind == vfs_pkg::ENT_FRAME) ? vfs_pkg::FR_LAST_MUL
                                                   : vfs_pkg::FIN_LAST_MUL;

  // magnitudes of the signed sources
  logic [FXY-1:0] m_fx, m_fy, m_tx, m_ty;
  logic [RXY-1:0] m_rx, m_ry;
  assign m_fx = e_fx[ix][FXY-1] ? FXY'(-e_fx[ix]) : FXY'(e_fx[ix]);
  assign m_fy = e_fx[iy][FXY-1] ? FXY'(-e_fx[iy]) : FXY'(e_fx[iy]);
  assign m_tx = txy[ix][FXY-1]  ? FXY'(-txy[ix])  : FXY'(txy[ix]);
  assign m_ty = txy[iy][FXY-1]  ? FXY'(-txy[iy])  : FXY'(txy[iy]);
  assign m_rx = rxy[ix][RXY-1]  ? RXY'(-rxy[ix])  : RXY'(rxy[ix]);
  assign m_ry = rxy[iy][RXY-1]  ? RXY'(-rxy[iy])  : RXY'(rxy[iy]);

  // divider operand select
  always_comb begin
    div_a = DW'(e_fsq[kind]);
    div_b = NDW'(e_p);
    if (e_kind == vfs_pkg::ENT_FRAME) begin
      unique case (step)
        vfs_pkg::ST_X: div_a = DW'(m_fx);
        vfs_pkg::ST_Y: div_a = DW'(m_fy);
        default:       div_a = DW'(e_fsq[kind]);
      endcase
    end else begin
      unique case (step)
        vfs_pkg::ST_X: begin
          div_a = DW'(m_rx);
          div_b = nreg;
        end
        vfs_pkg::ST_Y: begin
          div_a = DW'(m_ry);
          div_b = nreg;
        end
        vfs_pkg::ST_TX: begin
          div_a = DW'(m_tx);
          div_b = NDW'(e_f);
        end
        vfs_pkg::ST_TY: begin
          div_a = DW'(m_ty);
          div_b = NDW'(e_f);
        end
        vfs_pkg::ST_SV: begin
          div_a = DW'(svs[kind]);
          div_b = NDW'(e_f);
        end
        vfs_pkg::ST_TSQ: begin
          div_a = DW'(tsq[kind]);
          div_b = NDW'(e_f);
        end
        default: begin
          div_a = DW'(rsq[kind]);
          div_b = nreg;
        end
      endcase
    end
  end

  vfs_div #(.DW(DW), .NDW(NDW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .div_stat (div_stat),
    .quotient (div_q)
  );

  // finish means saturated to the velocity width
  logic          fsgn [4];
  logic [V-1:0]  fm   [4];
  logic [V-1:0]  fv   [4];
  assign fsgn[0] = rxy[ix][RXY-1];
  assign fsgn[1] = rxy[iy][RXY-1];
  assign fsgn[2] = txy[ix][FXY-1];
  assign fsgn[3] = txy[iy][FXY-1];
  for (genvar j = 0; j < 4; j++) begin : g_fin
    always_comb begin
      if (fsgn[j]) begin
        fm[j] = (q[j] > NEG_LIM) ? NEG_LIM[V-1:0] : q[j][V-1:0];
      end else begin
        fm[j] = (q[j] > POS_LIM) ? POS_LIM[V-1:0] : q[j][V-1:0];
      end
      fv[j] = fsgn[j] ? -fm[j] : fm[j];
    end
  end

  // squaring multiplier
  logic [MW-1:0]   mul_a;
  logic [2*MW-1:0] prod;
  assign mul_a = (e_kind == vfs_pkg::ENT_FRAME) ? q[step][MW-1:0] : MW'(fm[step[1:0]]);
  assign prod  = mul_a * mul_a;

  // frame close updates
  logic [NW-1:0]         mn_fr;
  logic [NW-1:0]         sv;
  logic [NW:0]           svs_s, tsq_s;
  logic [RSQ:0]          rsq_s;
  logic [FSQ-1:0]        svs_new, tsq_new;
  logic [RSQ-1:0]        rsq_new;
  logic signed [FXY-1:0] txy_new [2];
  logic signed [RXY-1:0] rxy_new [2];

  assign mn_fr   = sq[0] + sq[1];
  assign sv      = (q[vfs_pkg::ST_SQ] > mn_fr) ? q[vfs_pkg::ST_SQ] - mn_fr : '0;
  assign svs_s   = (NW+1)'(svs[kind]) + {1'b0, sv};
  assign tsq_s   = (NW+1)'(tsq[kind]) + {1'b0, mn_fr};
  assign rsq_s   = {1'b0, rsq[kind]} + (RSQ+1)'(e_fsq[kind]);
  assign svs_new = (svs_s > (NW+1)'({FSQ{1'b1}})) ? {FSQ{1'b1}} : svs_s[FSQ-1:0];
  assign tsq_new = (tsq_s > (NW+1)'({FSQ{1'b1}})) ? {FSQ{1'b1}} : tsq_s[FSQ-1:0];
  assign rsq_new = rsq_s[RSQ] ? {RSQ{1'b1}} : rsq_s[RSQ-1:0];

  for (genvar l = 0; l < 2; l++) begin : g_upd
    logic [1:0]            idx;
    logic signed [FXY:0]   mxs;
    logic signed [FXY+1:0] ts;
    logic signed [RXY:0]   rs;
    assign idx = {kind, l[0]};
    assign mxs = e_fx[idx][FXY-1] ? -{1'b0, q[l][FXY-1:0]} : {1'b0, q[l][FXY-1:0]};
    assign ts  = (FXY+2)'(txy[idx]) + (FXY+2)'(mxs);
    assign rs  = (RXY+1)'(rxy[idx]) + (RXY+1)'(e_fx[idx]);
    always_comb begin
      if (ts[FXY+1:FXY-1] == 3'b000 || ts[FXY+1:FXY-1] == 3'b111) begin
        txy_new[l] = ts[FXY-1:0];
      end else begin
        txy_new[l] = ts[FXY+1] ? {1'b1, {(FXY-1){1'b0}}} : {1'b0, {(FXY-1){1'b1}}};
      end
      if (rs[RXY] != rs[RXY-1]) begin
        rxy_new[l] = rs[RXY] ? {1'b1, {(RXY-1){1'b0}}} : {1'b0, {(RXY-1){1'b1}}};
      end else begin
        rxy_new[l] = rs[RXY-1:0];
      end
    end
  end

  // variance difference clamped to the output range
  function automatic logic [VARW-1:0] var_clip(input logic [DW-1:0] a,
                                                input logic [NW-1:0] b);
    logic [DW-1:0] d;
    d = (a > b) ? a - b : '0;
    if (d > DW'({VARW{1'b1}})) begin
      var_clip = {VARW{1'b1}};
    end else begin
      var_clip = d[VARW-1:0];
    end
  endfunction

  // square root step, two radicand bits per cycle
  logic [V+3:0] sr_cur;
  logic [V+3:0] sr_trial;
  assign sr_cur   = {sr_rem, sr_rad[2*V-1:2*V-2]};
  assign sr_trial = (V+4)'({sr_root, 2'b01});

  // sequencer next state
  always_comb begin
    state_next = state;
    step_next  = step;
    kind_next  = kind;
    div_start  = 1'b0;
    q_we       = 1'b0;
    mul_we     = 1'b0;
    sqrt_init  = 1'b0;
    sqrt_run   = 1'b0;
    upd_we     = 1'b0;
    out_load   = 1'b0;
    clr_run    = 1'b0;
    n_load     = 1'b0;
    pop        = 1'b0;
    unique case (state)
      vfs_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          state_next = vfs_pkg::BK_DIV;
          step_next  = '0;
          kind_next  = 1'b0;
          n_load     = 1'b1;
        end
      end
      vfs_pkg::BK_DIV: begin
        div_start = !div_stat.busy && !div_stat.done;
        if (div_stat.done) begin
          q_we = 1'b1;
          if (step == last_div) begin
            step_next  = '0;
            state_next = vfs_pkg::BK_MUL;
          end else begin
            step_next = step + 1'b1;
          end
        end
      end
      vfs_pkg::BK_MUL: begin
        mul_we = 1'b1;
        if (step == last_mul) begin
          step_next = '0;
          if (e_kind == vfs_pkg::ENT_FRAME) begin
            state_next = vfs_pkg::BK_UPDATE;
          end else begin
            sqrt_init  = 1'b1;
            state_next = vfs_pkg::BK_SQRT;
          end
        end else begin
          step_next = step + 1'b1;
        end
      end
      vfs_pkg::BK_SQRT: begin
        sqrt_run = 1'b1;
        if (sr_cnt == SCW'(1)) begin
          state_next = vfs_pkg::BK_EMIT;
        end
      end
      vfs_pkg::BK_UPDATE: begin
        upd_we = 1'b1;
        if (kind) begin
          pop        = 1'b1;
          state_next = vfs_pkg::BK_IDLE;
        end else begin
          kind_next  = 1'b1;
          step_next  = '0;
          state_next = vfs_pkg::BK_DIV;
        end
      end
      vfs_pkg::BK_EMIT: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          if (kind) begin
            clr_run    = 1'b1;
            pop        = 1'b1;
            state_next = vfs_pkg::BK_IDLE;
          end else begin
            kind_next  = 1'b1;
            step_next  = '0;
            state_next = vfs_pkg::BK_DIV;
          end
        end
      end
      default: state_next = vfs_pkg::BK_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vfs_pkg::BK_IDLE;
      step  <= '0;
      kind  <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      kind  <= kind_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (n_load) begin
      nreg <= NDW'(e_f) * NDW'(e_p);
    end
    if (q_we) begin
      q[step] <= div_q;
    end
    if (mul_we) begin
      sq[step[1:0]] <= prod[NW-1:0];
    end
    if (sqrt_init) begin
      sr_rad  <= (2*V)'(sq[0] + sq[1]);
      sr_rem  <= '0;
      sr_root <= '0;
      sr_cnt  <= SCW'(V);
    end else if (sqrt_run) begin
      sr_rad <= {sr_rad[2*V-3:0], 2'b00};
      sr_cnt <= sr_cnt - 1'b1;
      if (sr_cur >= sr_trial) begin
        sr_rem  <= (V+2)'(sr_cur - sr_trial);
        sr_root <= {sr_root[V-2:0], 1'b1};
      end else begin
        sr_rem  <= sr_cur[V+1:0];
        sr_root <= {sr_root[V-2:0], 1'b0};
      end
    end
  end

  // run totals
  always_ff @(posedge clk) begin
    if (rst || clr_run) begin
      for (int i = 0; i < 4; i++) begin
        rxy[i] <= '0;
        txy[i] <= '0;
      end
      for (int k = 0; k < 2; k++) begin
        rsq[k] <= '0;
        tsq[k] <= '0;
        svs[k] <= '0;
      end
    end else if (upd_we) begin
      svs[kind] <= svs_new;
      tsq[kind] <= tsq_new;
      rsq[kind] <= rsq_new;
      txy[ix]   <= txy_new[0];
      txy[iy]   <= txy_new[1];
      rxy[ix]   <= rxy_new[0];
      rxy[iy]   <= rxy_new[1];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      velocity_kind <= kind;
      last_result   <= kind;
      mean_x        <= fv[0];
      mean_y        <= fv[1];
      mean_speed    <= sr_root;
      space_var     <= var_clip(q[vfs_pkg::ST_SV], '0);
      time_var      <= var_clip(q[vfs_pkg::ST_TSQ], sq[2] + sq[3]);
      ensemble_var  <= var_clip(q[vfs_pkg::ST_RSQ], sq[0] + sq[1]);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/velocity_fluctuation_statistics.sv =====
// ----------------------------------------------------------------------------
// velocity_fluctuation_statistics
// Running mean and variance of advected and centre of mass velocities over
// frames of samples, with results emitted on a finish transaction.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    mode, adv_vx, adv_vy, com_vx, com_vy
//   out      output     out_valid / out_ready  velocity_kind .. last_result
//   cfg      input      cfg_wr_en              cfg_index, cfg_data
//
// A sample that does not close a frame is taken every cycle. A frame close
// costs the back end, for each of the two kinds, three 64-step divisions,
// two squarings and one update; a finish costs seven divisions, four
// squarings, a square root and a result per kind. The front keeps taking
// samples while the back works; it stalls only on a closing or finish
// transaction when the two-entry queue has no room. Reset is synchronous
// and clears all sums, the queue and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module velocity_fluctuation_statistics #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_FRAMES = 1024,
  parameter int VEL_WIDTH  = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          mode,
  input  wire logic signed [VEL_WIDTH-1:0]   adv_vx,
  input  wire logic signed [VEL_WIDTH-1:0]   adv_vy,
  input  wire logic signed [VEL_WIDTH-1:0]   com_vx,
  input  wire logic signed [VEL_WIDTH-1:0]   com_vy,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               velocity_kind,
  output logic signed [VEL_WIDTH-1:0]        mean_x,
  output logic signed [VEL_WIDTH-1:0]        mean_y,
  output logic [VEL_WIDTH-1:0]               mean_speed,
  output logic [2*VEL_WIDTH-1:0]             space_var,
  output logic [2*VEL_WIDTH-1:0]             time_var,
  output logic [2*VEL_WIDTH-1:0]             ensemble_var,
  output logic                               last_result,
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_index,
  input  wire logic [vfs_pkg::CFG_W-1:0]     cfg_data
);

  localparam int PW  = $clog2(MAX_POINTS + 1);
  localparam int FW  = $clog2(MAX_FRAMES + 1);
  localparam int FXY = VEL_WIDTH + vfs_pkg::FRAME_GROW;
  localparam int FSQ = 2 * VEL_WIDTH + vfs_pkg::SQ_GROW;
  localparam int EW  = 1 + PW + FW + 2 * FSQ + 4 * FXY;

  logic [vfs_pkg::CFG_W-1:0] reg_ppf;
  logic [vfs_pkg::CFG_W-1:0] reg_fc;
  logic [PW-1:0]             p_eff;
  logic [FW-1:0]             f_eff;

  logic                      push;
  logic [EW-1:0]             push_data;
  logic                      pop;
  logic [EW-1:0]             head;
  vfs_pkg::q_stat_t          q_stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_ppf <= vfs_pkg::CFG_W'(1);
      reg_fc  <= vfs_pkg::CFG_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        vfs_pkg::REG_PPF: reg_ppf <= cfg_data;
        vfs_pkg::REG_FC:  reg_fc  <= cfg_data;
        default:          reg_fc  <= reg_fc;
      endcase
    end
  end

  // effective frame size and frame count, clamped to one and the maximum
  always_comb begin
    if (reg_ppf == '0) begin
      p_eff = PW'(1);
    end else if (32'(reg_ppf) > MAX_POINTS) begin
      p_eff = PW'(MAX_POINTS);
    end else begin
      p_eff = PW'(reg_ppf);
    end
    if (reg_fc == '0) begin
      f_eff = FW'(1);
    end else if (32'(reg_fc) > MAX_FRAMES) begin
      f_eff = FW'(MAX_FRAMES);
    end else begin
      f_eff = FW'(reg_fc);
    end
  end

  vfs_front #(.V(VEL_WIDTH), .PW(PW), .FW(FW), .EW(EW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .adv_vx    (adv_vx),
    .adv_vy    (adv_vy),
    .com_vx    (com_vx),
    .com_vy    (com_vy),
    .p_eff     (p_eff),
    .f_eff     (f_eff),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  vfs_queue #(.W(EW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_stat    (q_stat),
    .head      (head)
  );

  vfs_back #(.V(VEL_WIDTH), .PW(PW), .FW(FW), .EW(EW)) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .velocity_kind (velocity_kind),
    .mean_x        (mean_x),
    .mean_y        (mean_y),
    .mean_speed    (mean_speed),
    .space_var     (space_var),
    .time_var      (time_var),
    .ensemble_var  (ensemble_var),
    .last_result   (last_result)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_velocity_fluctuation_statistics.sv =====
// ----------------------------------------------------------------------------
// tb_velocity_fluctuation_statistics
// Self-checking bench for the velocity statistics block. A directed table
// covers finish after reset, extreme velocities, out-of-range register
// values, a frame size change part way through a frame and discarded partial
// frames. Random runs of whole frames, some with a partial tail, follow. Results
// are compared with an in-bench model of the accumulators or, for typed rows, with table values.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_velocity_fluctuation_statistics;

  localparam int VW = 24;
  localparam int LIMIT_CYCLES = 3000000;
  localparam int SETTLE_CYCLES = 1500;
  localparam longint VMIN = -(64'sd1 <<< 23);
  localparam longint VMAX = (64'sd1 <<< 23) - 1;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    logic              kind;
    logic              vkind;
    logic signed [VW-1:0] mx;
    logic signed [VW-1:0] my;
    logic [VW-1:0]     speed;
    logic [2*VW-1:0]   sv;
    logic [2*VW-1:0]   tv;
    logic [2*VW-1:0]   ev;
    logic              last;
  } stats_t;

  typedef struct {
    row_kind_t         kind;
    logic [vfs_pkg::CFG_W-1:0]  ppf;
    logic [vfs_pkg::CFG_W-1:0]  fc;
    logic              mode;
    logic signed [VW-1:0] v [4];
    bit                typed;
    logic signed [VW-1:0] tmx [2];
    logic signed [VW-1:0] tmy [2];
    logic [VW-1:0]     tsp [2];
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = vfs_pkg::MODE_SAMPLE;
  logic signed [VW-1:0] adv_vx = '0, adv_vy = '0, com_vx = '0, com_vy = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic velocity_kind;
  logic signed [VW-1:0] mean_x, mean_y;
  logic [VW-1:0] mean_speed;
  logic [2*VW-1:0] space_var, time_var, ensemble_var;
  logic last_result;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = vfs_pkg::REG_PPF;
  logic [vfs_pkg::CFG_W-1:0] cfg_data = '0;

  velocity_fluctuation_statistics u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .adv_vx(adv_vx), .adv_vy(adv_vy), .com_vx(com_vx), .com_vy(com_vy),
    .out_valid(out_valid), .out_ready(out_ready),
    .velocity_kind(velocity_kind), .mean_x(mean_x), .mean_y(mean_y),
    .mean_speed(mean_speed), .space_var(space_var), .time_var(time_var),
    .ensemble_var(ensemble_var), .last_result(last_result),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // model state
  logic [vfs_pkg::CFG_W-1:0] cur_ppf, cur_fc;
  longint fsum [4], rsum [4], tsum [4];
  bit [63:0] fsq [2], rsq [2], tsq [2], svs [2];
  int pcnt;

  stats_t stats_q [$];
  row_t dir_rows [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int finishes = 0;
  int frames_closed = 0;
  int hold_req = 0;
  bit no_idle = 0;
  longint cycles = 0;

  // ---------------------------------------------------------------- arithmetic
  function automatic bit [63:0] wmask(int w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic longint sat_signed(longint v, int w);
    longint hi, lo;
    hi = longint'((64'd1 << (w - 1)) - 64'd1);
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic bit [63:0] sat_add(bit [63:0] a, bit [63:0] b, int w);
    bit [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, wmask(w)}) ? wmask(w) : s[63:0];
  endfunction

  function automatic bit [63:0] magn(longint a);
    return (a < 0) ? (64'd0 - 64'(a)) : 64'(a);
  endfunction

  function automatic longint div_trunc(longint a, bit [63:0] d);
    bit [63:0] q;
    q = magn(a) / d;
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit [63:0] norm_sq(longint x, longint y);
    bit [63:0] ux, uy;
    ux = magn(x);
    uy = magn(y);
    return ux * ux + uy * uy;
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit [2*VW-1:0] var_clip(bit [63:0] a, bit [63:0] b);
    bit [63:0] d;
    d = (a > b) ? a - b : 64'd0;
    return (d > wmask(2 * VW)) ? '1 : d[2*VW-1:0];
  endfunction

  function automatic bit [63:0] eff_reg(logic [vfs_pkg::CFG_W-1:0] v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // -------------------------------------------------------------- statistics
  task automatic clear_sums();
    for (int i = 0; i < 4; i++) begin
      fsum[i] = 0; rsum[i] = 0; tsum[i] = 0;
    end
    for (int k = 0; k < 2; k++) begin
      fsq[k] = 0; rsq[k] = 0; tsq[k] = 0; svs[k] = 0;
    end
    pcnt = 0;
  endtask

  // fold the finished frame into the run totals
  task automatic close_frame(bit [63:0] p);
    longint mx, my;
    bit [63:0] msq, mn, sv;
    for (int k = 0; k < 2; k++) begin
      mx = div_trunc(fsum[2*k], p);
      my = div_trunc(fsum[2*k+1], p);
      msq = fsq[k] / p;
      mn = norm_sq(mx, my);
      sv = (msq > mn) ? msq - mn : 64'd0;
      svs[k] = sat_add(svs[k], sv, 58);
      tsq[k] = sat_add(tsq[k], mn, 58);
      tsum[2*k] = sat_signed(tsum[2*k] + mx, 34);
      tsum[2*k+1] = sat_signed(tsum[2*k+1] + my, 34);
      rsq[k] = sat_add(rsq[k], fsq[k], 64);
      fsq[k] = 0;
    end
    for (int i = 0; i < 4; i++) begin
      rsum[i] = sat_signed(rsum[i] + fsum[i], 44);
      fsum[i] = 0;
    end
    pcnt = 0;
    frames_closed++;
  endtask

  // advance the statistics by one accepted transaction; queue results if asked
  task automatic update_stats(logic m, logic signed [VW-1:0] v [4], bit push);
    bit [63:0] p, f, n, mn;
    longint vv [4];
    longint mx, my, tx, ty;
    stats_t r;
    p = eff_reg(cur_ppf, 1024);
    if (m == vfs_pkg::MODE_SAMPLE) begin
      for (int i = 0; i < 4; i++) begin
        vv[i] = v[i];
        fsum[i] = sat_signed(fsum[i] + vv[i], 34);
      end
      for (int k = 0; k < 2; k++)
        fsq[k] = sat_add(fsq[k], norm_sq(vv[2*k], vv[2*k+1]), 58);
      pcnt++;
      if (pcnt >= p) close_frame(p);
    end else begin
      f = eff_reg(cur_fc, 1024);
      n = f * p;
      for (int k = 0; k < 2; k++) begin
        mx = sat_signed(div_trunc(rsum[2*k], n), VW);
        my = sat_signed(div_trunc(rsum[2*k+1], n), VW);
        tx = sat_signed(div_trunc(tsum[2*k], f), VW);
        ty = sat_signed(div_trunc(tsum[2*k+1], f), VW);
        mn = norm_sq(mx, my);
        r.vkind = k[0];
        r.mx = mx[VW-1:0];
        r.my = my[VW-1:0];
        r.speed = VW'(int_sqrt(mn));
        r.sv = var_clip(svs[k] / f, 0);
        r.tv = var_clip(tsq[k] / f, norm_sq(tx, ty));
        r.ev = var_clip(rsq[k] / n, mn);
        r.last = k[0];
        if (push) stats_q.push_back(r);
      end
      clear_sums();
      finishes++;
    end
  endtask

  // ------------------------------------------------------------------ driving
  function automatic logic signed [VW-1:0] rand_vel();
    case ($urandom_range(0, 7))
      0: return VMIN[VW-1:0];
      1: return VMAX[VW-1:0];
      2: return VW'(int'($urandom_range(0, 2048)) - 1024);
      default: return VW'($urandom);
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_item(logic m, logic signed [VW-1:0] v [4], bit push);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode = m;
    adv_vx = v[0]; adv_vy = v[1]; com_vx = v[2]; com_vy = v[3];
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    update_stats(m, v, push);
    @(negedge clk);
  endtask

  task automatic send_sample();
    logic signed [VW-1:0] v [4];
    for (int i = 0; i < 4; i++) v[i] = rand_vel();
    send_item(vfs_pkg::MODE_SAMPLE, v, 1'b1);
  endtask

  task automatic send_finish();
    logic signed [VW-1:0] v [4];
    for (int i = 0; i < 4; i++) v[i] = rand_vel();
    send_item(vfs_pkg::MODE_FINISH, v, 1'b1);
  endtask

  // registers change only once the block has gone quiet
  task automatic set_config(logic [vfs_pkg::CFG_W-1:0] ppf, logic [vfs_pkg::CFG_W-1:0] fc);
    in_valid = 1'b0;
    while (stats_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en = 1'b1; cfg_index = vfs_pkg::REG_PPF; cfg_data = ppf;
    @(negedge clk);
    cfg_index = vfs_pkg::REG_FC; cfg_data = fc;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cur_ppf = ppf;
    cur_fc = fc;
  endtask

  // --------------------------------------------------------- directed table
  function automatic row_t cfg_row(int ppf, int fc);
    row_t r;
    r.kind = ROW_CFG;
    r.ppf = vfs_pkg::CFG_W'(ppf);
    r.fc = vfs_pkg::CFG_W'(fc);
    r.mode = vfs_pkg::MODE_SAMPLE;
    r.typed = 0;
    return r;
  endfunction

  function automatic row_t item_row(logic m, longint a, longint b, longint c, longint d);
    row_t r;
    r.kind = ROW_ITEM;
    r.mode = m;
    r.v[0] = VW'(a); r.v[1] = VW'(b); r.v[2] = VW'(c); r.v[3] = VW'(d);
    r.typed = 0;
    return r;
  endfunction

  function automatic row_t typed_finish(longint mx0, longint my0, longint sp0,
                                        longint mx1, longint my1, longint sp1);
    row_t r;
    r = item_row(vfs_pkg::MODE_FINISH, 0, 0, 0, 0);
    r.typed = 1;
    r.tmx[0] = VW'(mx0); r.tmy[0] = VW'(my0); r.tsp[0] = VW'(sp0);
    r.tmx[1] = VW'(mx1); r.tmy[1] = VW'(my1); r.tsp[1] = VW'(sp1);
    return r;
  endfunction

  task automatic build_table();
    // finish straight after reset gives all zeros
    dir_rows.push_back(typed_finish(0, 0, 0, 0, 0, 0));
    // single extreme sample per kind, one-point frames
    dir_rows.push_back(item_row(vfs_pkg::MODE_SAMPLE, VMIN, VMIN, VMAX, VMAX));
    dir_rows.push_back(typed_finish(VMIN, VMIN, 11863283, VMAX, VMAX, 11863281));
    // zero frame size acts as one
    dir_rows.push_back(cfg_row(0, 1));
    dir_rows.push_back(item_row(vfs_pkg::MODE_SAMPLE, 0, VMAX, VMIN, 1));
    dir_rows.push_back(item_row(vfs_pkg::MODE_SAMPLE, -1, 5, VMAX, -7));
    dir_rows.push_back(item_row(vfs_pkg::MODE_FINISH, 0, 0, 0, 0));
    // frame shrinks part way through: closes on the next sample
    dir_rows.push_back(cfg_row(4, 2));
    dir_rows.push_back(item_row(vfs_pkg::MODE_SAMPLE, 100, -200, 300, -400));
    dir_rows.push_back(item_row(vfs_pkg::MODE_SAMPLE, VMAX, VMAX, VMIN, VMIN));
    dir_rows.push_back(item_row(vfs_pkg::MODE_SAMPLE, -3, 3, 12345, -54321));
    dir_rows.push_back(cfg_row(2, 2));
    dir_rows.push_back(item_row(vfs_pkg::MODE_SAMPLE, 7, 8, 9, 10));
    // partial frame is dropped at finish
    dir_rows.push_back(item_row(vfs_pkg::MODE_SAMPLE, VMIN, 0, 0, VMIN));
    dir_rows.push_back(item_row(vfs_pkg::MODE_FINISH, 0, 0, 0, 0));
    // oversized frame size and zero frame count
    dir_rows.push_back(cfg_row(2047, 0));
    dir_rows.push_back(item_row(vfs_pkg::MODE_SAMPLE, 1, 2, 3, 4));
    dir_rows.push_back(item_row(vfs_pkg::MODE_FINISH, 0, 0, 0, 0));
    // largest frame count, one-point frames
    dir_rows.push_back(cfg_row(1, 2047));
    dir_rows.push_back(item_row(vfs_pkg::MODE_SAMPLE, VMAX, VMIN, VMAX, VMIN));
    dir_rows.push_back(item_row(vfs_pkg::MODE_SAMPLE, VMAX, VMIN, VMAX, VMIN));
    dir_rows.push_back(item_row(vfs_pkg::MODE_FINISH, 0, 0, 0, 0));
    // frame count smaller than real frames: means saturate
    dir_rows.push_back(cfg_row(1, 1024));
    dir_rows.push_back(cfg_row(1, 1));
    dir_rows.push_back(item_row(vfs_pkg::MODE_SAMPLE, VMAX, VMIN, VMAX, VMIN));
    dir_rows.push_back(item_row(vfs_pkg::MODE_SAMPLE, VMAX, VMIN, VMAX, VMIN));
    dir_rows.push_back(item_row(vfs_pkg::MODE_FINISH, 0, 0, 0, 0));
  endtask

  task automatic run_table();
    stats_t r;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        set_config(dir_rows[i].ppf, dir_rows[i].fc);
      end else begin
        send_item(dir_rows[i].mode, dir_rows[i].v, !dir_rows[i].typed);
        if (dir_rows[i].typed) begin
          for (int k = 0; k < 2; k++) begin
            r.vkind = k[0];
            r.mx = dir_rows[i].tmx[k];
            r.my = dir_rows[i].tmy[k];
            r.speed = dir_rows[i].tsp[k];
            r.sv = '0; r.tv = '0; r.ev = '0;
            r.last = k[0];
            stats_q.push_back(r);
          end
        end
      end
    end
  endtask

  // one run of whole frames, sometimes with a ragged tail, then finish
  task automatic random_run(int p);
    int nf, tail;
    nf = (p > 16) ? $urandom_range(1, 2) : $urandom_range(0, 6);
    tail = (p > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, p - 1) : 0;
    repeat (nf * p + tail) send_sample();
    send_finish();
  endtask

  // ------------------------------------------------------------- receiver side
  always @(negedge clk) begin
    static int burst = 0;
    static int hold_left = 0;
    logic rdy;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (burst > 0) begin
      burst--;
      rdy = 1'b0;
    end else if (!no_idle && $urandom_range(0, 4) == 0) begin
      burst = $urandom_range(1, 14) - 1;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    out_ready <= rdy;
  end

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, field, got, want);
  endtask

  // compare each result transaction against the oldest expectation
  always @(posedge clk) begin
    stats_t e;
    cycles++;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (stats_q.size() == 0) begin
        errors++;
        $display("unexpected result transaction %0d", results_seen);
      end else begin
        e = stats_q.pop_front();
        if (velocity_kind !== e.vkind) report_mismatch("velocity_kind", velocity_kind, e.vkind);
        if (mean_x !== e.mx) report_mismatch("mean_x", mean_x, e.mx);
        if (mean_y !== e.my) report_mismatch("mean_y", mean_y, e.my);
        if (mean_speed !== e.speed) report_mismatch("mean_speed", mean_speed, e.speed);
        if (space_var !== e.sv) report_mismatch("space_var", space_var, e.sv);
        if (time_var !== e.tv) report_mismatch("time_var", time_var, e.tv);
        if (ensemble_var !== e.ev) report_mismatch("ensemble_var", ensemble_var, e.ev);
        if (last_result !== e.last) report_mismatch("last_result", last_result, e.last);
      end
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL velocity_fluctuation_statistics");
      $finish;
    end
  end

  // ------------------------------------------------------------------- main
  initial begin
    int phase;
    int p, fc;
    cur_ppf = 1;
    cur_fc = 1;
    clear_sums();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    build_table();
    run_table();

    phase = 0;
    while (items_sent < 550) begin
      case ($urandom_range(0, 9))
        0: p = $urandom_range(17, 40);
        1: p = 0;
        default: p = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 7))
        0: fc = 0;
        1: fc = 1024;
        2: fc = 2047;
        default: fc = $urandom_range(1, 8);
      endcase
      set_config(vfs_pkg::CFG_W'(p), vfs_pkg::CFG_W'(fc));
      if (items_sent > 470) no_idle = 1;
      if (phase == 2) begin
        // result side goes quiet while one-point frames keep arriving
        set_config(vfs_pkg::CFG_W'(1), vfs_pkg::CFG_W'(fc));
        send_finish();
        hold_req = 4000;
        repeat (40) send_sample();
        send_finish();
      end else begin
        random_run((p == 0) ? 1 : p);
      end
      phase++;
    end

    in_valid = 1'b0;
    while (stats_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d transactions in, %0d frames, %0d runs finished, %0d results",
             items_sent, frames_closed, finishes, results_seen);
    $display("%0d field mismatches over %0d cycles", errors, cycles);
    if (errors == 0) begin
      $display("PASS velocity_fluctuation_statistics");
    end else begin
      $display("FAIL velocity_fluctuation_statistics");
    end
    $finish;
  end

endmodule

`default_nettype wire
